@@ hw/rtl/zvc_pkg.sv @@
package zvc_pkg;

    localparam int VALUE_BITS_DEF = 64;  // default width of the coded value
    localparam int VAL_W          = 64;  // width of value_in and value_out
    localparam int BYTE_W         = 8;
    localparam int DIGIT_W        = 7;   // data bits carried by one coded byte

    // Operation selected by cmd.
    localparam logic CMD_ENC = 1'b0;
    localparam logic CMD_DEC = 1'b1;

    // Controller states of the top level.
    typedef enum logic {
        ST_IDLE,
        ST_ENC
    } t_state;

    // One result transaction as it sits in the output register.
    typedef struct packed {
        logic                 is_value;
        logic [BYTE_W-1:0]    out_byte;
        logic [VAL_W-1:0]     value_out;
        logic                 last;
        logic                 truncated;
        logic                 overflow_error;
    } t_res;

    // Status of the decoder for the byte currently offered.
    typedef struct packed {
        logic emit;       // this byte closes the value and yields a result
        logic truncated;
        logic overflow;
    } t_dec_stat;

endpackage

@@ hw/rtl/zvc_enc.sv @@
module zvc_enc #(
    parameter int VALUE_BITS = zvc_pkg::VALUE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_load,
    input  logic [zvc_pkg::VAL_W-1:0] i_value,
    input  logic                      i_step,
    output zvc_pkg::t_res             o_res
);
    import zvc_pkg::*;

    logic [VALUE_BITS-1:0] r_sh;
    logic [VALUE_BITS-1:0] n_sh;
    logic [VALUE_BITS-1:0] w_n;
    logic [VALUE_BITS-1:0] w_zz;
    logic                  w_more;

    // Zigzag mapping: shift left one and flip every bit of a negative value.
    assign w_n  = i_value[VALUE_BITS-1:0];
    assign w_zz = {w_n[VALUE_BITS-2:0], 1'b0} ^ {VALUE_BITS{w_n[VALUE_BITS-1]}};

    // More bytes follow while anything is left above the low group.
    assign w_more = |r_sh[VALUE_BITS-1:DIGIT_W];

    always_comb begin
        n_sh = r_sh;
        if (i_load) begin
            n_sh = w_zz;
        end else if (i_step) begin
            n_sh = r_sh >> DIGIT_W;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh <= n_sh;
    end

    always_comb begin
        o_res                = '0;
        o_res.is_value       = 1'b0;
        o_res.out_byte       = {w_more, r_sh[DIGIT_W-1:0]};
        o_res.last           = !w_more;
    end

endmodule

@@ hw/rtl/zvc_dec.sv @@
module zvc_dec #(
    parameter int VALUE_BITS = zvc_pkg::VALUE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [zvc_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_eod,
    output zvc_pkg::t_dec_stat         o_stat,
    output zvc_pkg::t_res              o_res
);
    import zvc_pkg::*;

    localparam int MAXG  = (VALUE_BITS + DIGIT_W - 1) / DIGIT_W;
    localparam int ACC_W = MAXG * DIGIT_W;

    // The accumulator is split into digit lanes; a one-hot window marks the
    // lane that takes the next group, so it also stands for the group count.
    logic [ACC_W-1:0]             r_acc;
    logic [ACC_W-1:0]             n_acc;
    logic [MAXG-1:0]              r_win;
    logic [MAXG-1:0]              n_win;
    logic [ACC_W-1:0]             w_acc;
    logic [VALUE_BITS-1:0]        w_zz;
    logic signed [VALUE_BITS-1:0] w_val;
    logic                         w_cont;

    always_comb begin
        w_acc = r_acc;
        for (int j = 0; j < MAXG; j++) begin
            if (r_win[j]) begin
                w_acc[j*DIGIT_W +: DIGIT_W] = r_acc[j*DIGIT_W +: DIGIT_W]
                                              | i_byte[DIGIT_W-1:0];
            end
        end
    end

    // Zigzag unmapping: shift right one and flip all bits when the low bit is set.
    assign w_zz  = w_acc[VALUE_BITS-1:0];
    assign w_val = (w_zz >> 1) ^ {VALUE_BITS{w_zz[0]}};

    assign w_cont = i_byte[BYTE_W-1];

    always_comb begin
        o_stat.overflow  = w_cont && r_win[MAXG-1];
        o_stat.truncated = w_cont && !r_win[MAXG-1] && i_eod;
        o_stat.emit      = !w_cont || r_win[MAXG-1] || i_eod;
    end

    always_comb begin
        o_res                = '0;
        o_res.is_value       = 1'b1;
        o_res.truncated      = o_stat.truncated;
        o_res.overflow_error = o_stat.overflow;
        o_res.value_out      = o_stat.overflow ? '0 : VAL_W'(w_val);
    end

    always_comb begin
        n_acc = r_acc;
        n_win = r_win;
        if (i_step) begin
            if (o_stat.emit) begin
                n_acc = '0;
                n_win = MAXG'(1);
            end else begin
                n_acc = w_acc;
                n_win = {r_win[MAXG-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_win <= MAXG'(1);
        end else begin
            r_acc <= n_acc;
            r_win <= n_win;
        end
    end

endmodule

@@ hw/rtl/zigzag_varint_codec.sv @@
// Channel | Direction | tdata (low bit up)          | tuser (low bit up)                 | tlast
// s_      | input     | value_in[63:0], in_byte[7:0] | cmd                                | end_of_data
// m_      | output    | out_byte[7:0], value_out[63:0] | is_value, truncated, overflow_error | last
//
// A decode transaction's result, if any, sits in the output register in the cycle after
// it is accepted. An encode transaction first loads the zigzag shift register, then the
// encoder register shifts out 7 bits at a time, one coded byte (1 to 10 at 64 bits) per
// step into the output register. Reset is synchronous and active low; it empties
// the output register and clears the decoder accumulator. A stalled master side holds
// the output register and the encoder shift, and s_tready stays low until space frees up.
module zigzag_varint_codec #(
    parameter int VALUE_BITS = zvc_pkg::VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // value_in[63:0], in_byte[71:64]
    input  logic [0:0]  s_tuser,   // cmd
    input  logic        s_tlast,   // end_of_data
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // out_byte[7:0], value_out[71:8]
    output logic [2:0]  m_tuser,   // is_value, truncated, overflow_error
    output logic        m_tlast    // last
);
    import zvc_pkg::*;

    t_state    r_state;
    t_state    n_state;
    t_res      r_res;
    t_res      n_res;
    logic      r_mvalid;
    logic      n_mvalid;

    t_res      w_enc_res;
    t_res      w_dec_res;
    t_dec_stat w_dec_stat;

    logic      w_out_free;
    logic      w_accept;
    logic      w_enc_load;
    logic      w_enc_step;
    logic      w_dec_step;
    logic      w_load_out;
    logic      w_sel_enc;

    // The output register can take a new result when empty or draining now.
    assign w_out_free = !r_mvalid || m_tready;
    assign w_accept   = s_tvalid && s_tready;

    zvc_enc #(
        .VALUE_BITS (VALUE_BITS)
    ) u_enc (
        .i_clk   (i_clk),
        .i_load  (w_enc_load),
        .i_value (s_tdata[VAL_W-1:0]),
        .i_step  (w_enc_step),
        .o_res   (w_enc_res)
    );

    zvc_dec #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_dec_step),
        .i_byte  (s_tdata[VAL_W +: BYTE_W]),
        .i_eod   (s_tlast),
        .o_stat  (w_dec_stat),
        .o_res   (w_dec_res)
    );

    // Next state: an encode transaction runs until its last byte has moved
    // into the output register.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (s_tuser[0] == CMD_ENC)) begin
                    n_state = ST_ENC;
                end
            end
            ST_ENC: begin
                if (w_out_free && w_enc_res.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Controller outputs.
    always_comb begin
        s_tready   = 1'b0;
        w_enc_load = 1'b0;
        w_enc_step = 1'b0;
        w_dec_step = 1'b0;
        w_load_out = 1'b0;
        w_sel_enc  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_tready   = w_out_free;
                w_enc_load = w_accept && (s_tuser[0] == CMD_ENC);
                w_dec_step = w_accept && (s_tuser[0] == CMD_DEC);
                w_load_out = w_dec_step && w_dec_stat.emit;
            end
            ST_ENC: begin
                w_sel_enc  = 1'b1;
                w_enc_step = w_out_free;
                w_load_out = w_out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_res    = r_res;
        n_mvalid = r_mvalid && !m_tready;
        if (w_load_out) begin
            n_res    = w_sel_enc ? w_enc_res : w_dec_res;
            n_mvalid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_mvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mvalid <= n_mvalid;
        end
    end

    // The result payload needs no reset; the valid flag qualifies it.
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign m_tvalid = r_mvalid;
    assign m_tdata  = {r_res.value_out, r_res.out_byte};
    assign m_tuser  = {r_res.overflow_error, r_res.truncated, r_res.is_value};
    assign m_tlast  = r_res.last;

`ifndef SYNTHESIS
    // While an encode transaction is being emitted no new item may enter.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ENC) |-> !s_tready)
        else $error("input accepted during encode emission");

    // An overflow result carries a zero value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mvalid && r_res.overflow_error) |-> (r_res.value_out == '0))
        else $error("overflow result with nonzero value");

    // The final coded byte of a value never has its continuation bit set.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mvalid && r_res.last) |-> (!r_res.is_value && !r_res.out_byte[BYTE_W-1]))
        else $error("last byte with continuation bit");

    // After an encode load the controller is emitting bytes.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_enc_load |=> (r_state == ST_ENC))
        else $error("encode load did not start emission");
`endif

endmodule

@@ verif/zigzag_varint_codec_test.sv @@
`timescale 1ns / 100ps

module zigzag_varint_codec_test;

    import zvc_pkg::*;

    localparam int   MAX_GROUPS   = 10;     // 7-bit groups in a 64-bit zigzag value
    localparam int   HOLD_CYCLES  = 300;    // long output stall
    localparam int   LATENCY_TAIL = 16;     // cycles allowed past the last expected result
    localparam int   RANDOM_ITEMS = 100;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;     // value_in[63:0], in_byte[71:64]
    logic [0:0]  s_tuser = '0;     // cmd
    logic        s_tlast = 1'b0;   // end_of_data
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;          // out_byte[7:0], value_out[71:8]
    logic [2:0]  m_tuser;          // is_value, truncated, overflow_error
    logic        m_tlast;          // last

    // Expected result transactions, oldest first.
    t_res pending_results[$];

    // Decoder accumulator as the block should hold it.
    logic [63:0] acc_bits = '0;
    int unsigned acc_groups = 0;

    int errors = 0;
    int items_sent = 0;
    int n_encodes = 0;
    int n_dec_bytes = 0;
    int n_checked = 0;
    int n_trunc = 0;
    int n_overflow = 0;

    // When set, neither side inserts idle cycles.
    logic steady = 1'b0;
    logic hold_req = 1'b0;
    int   hold_left = 0;

    zigzag_varint_codec u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // Zigzag-maps a value and returns its coded bytes, byte k in bits 8k+7..8k.
    function automatic logic [79:0] varint_pack(input logic [63:0] v, output int n);
        logic [63:0] z;
        logic [79:0] groups;
        z = {v[62:0], 1'b0} ^ {64{v[63]}};
        groups = '0;
        n = 0;
        while (z >= 64'h80 && n < MAX_GROUPS - 1) begin
            groups[8*n +: 8] = {1'b1, z[6:0]};
            z = z >> 7;
            n++;
        end
        groups[8*n +: 8] = {1'b0, z[6:0]};
        n++;
        return groups;
    endfunction

    function automatic logic [63:0] zz_unmap(input logic [63:0] z);
        return (z >> 1) ^ {64{z[0]}};
    endfunction

    task automatic predict_encode(input logic [63:0] v);
        logic [79:0] coded;
        int n;
        t_res r;
        coded = varint_pack(v, n);
        for (int k = 0; k < n; k++) begin
            r = '0;
            r.out_byte = coded[8*k +: 8];
            r.last = (k == n - 1);
            pending_results = {pending_results, r};
        end
        n_encodes++;
    endtask

    task automatic predict_decode(input logic [7:0] b, input logic eod);
        int unsigned g;
        t_res r;
        n_dec_bytes++;
        g = (acc_groups >= MAX_GROUPS) ? MAX_GROUPS - 1 : acc_groups;
        // Group bits that land above bit 63 simply fall off.
        acc_bits = acc_bits | ({57'd0, b[6:0]} << (7 * g));
        r = '0;
        r.is_value = 1'b1;
        if (!b[7]) begin
            r.value_out = zz_unmap(acc_bits);
        end else if (g + 1 >= MAX_GROUPS) begin
            // Overflow takes priority over end of data and reports no value.
            r.overflow_error = 1'b1;
            n_overflow++;
        end else if (eod) begin
            r.value_out = zz_unmap(acc_bits);
            r.truncated = 1'b1;
            n_trunc++;
        end else begin
            acc_groups = g + 1;
            return;
        end
        pending_results = {pending_results, r};
        acc_bits = '0;
        acc_groups = 0;
    endtask

    // Offers one input transaction, waits for it to be taken and records the
    // results it should cause.
    task automatic send_item(input logic cmd, input logic [63:0] value,
                             input logic [7:0] in_b, input logic eod);
        int gap;
        @(negedge i_clk);
        if (!steady && $urandom_range(99) < 12) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(4, 1);
            repeat (gap) @(negedge i_clk);
        end
        s_tdata  <= {in_b, value};
        s_tuser  <= cmd;
        s_tlast  <= eod;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        items_sent++;
        if (cmd == CMD_ENC)
            predict_encode(value);
        else
            predict_decode(in_b, eod);
    endtask

    // Stops offering input and waits until every expected result has come.
    task automatic wait_drained();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_encode(input logic [63:0] v);
        send_item(CMD_ENC, v, 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    task automatic send_decode(input logic [7:0] b, input logic eod);
        send_item(CMD_DEC, rnd64(), b, eod);
    endtask

    // Encodes of zero, small values on both sides of a byte boundary and both
    // ends of the signed range.
    task automatic test_encode_edges();
        send_encode(64'd0);
        send_encode(64'hFFFF_FFFF_FFFF_FFFF);
        send_encode(64'd64);
        send_encode(-64'sd65);
        send_encode(64'h7FFF_FFFF_FFFF_FFFF);
        send_encode(64'h8000_0000_0000_0000);
        wait_drained();
    endtask

    // Single-byte values, a two-byte value whose terminator also carries end
    // of data, a truncated value and a run of ten continuation bytes.
    task automatic test_decode_edges();
        send_decode(8'h00, 1'b0);
        send_decode(8'h7F, 1'b0);
        send_decode(8'h80, 1'b0);
        send_decode(8'h01, 1'b1);
        send_decode(8'hFF, 1'b1);
        for (int k = 0; k < MAX_GROUPS; k++)
            send_decode(8'hFF, k == MAX_GROUPS - 1);
        wait_drained();
    endtask

    // Mostly well-formed coded streams, plus encodes, stray bytes and runs
    // long enough to overflow or to push bits past the top of the value.
    task automatic test_random_mix();
        logic [63:0] v;
        logic [79:0] coded;
        int n, cut, pick, first;
        first = items_sent;
        steady = 1'b1;
        while (items_sent < first + RANDOM_ITEMS) begin
            if (items_sent >= first + 40)
                steady = 1'b0;
            pick = $urandom_range(99);
            v = rnd64();
            if ($urandom_range(3) != 0)
                v = $signed(v) >>> $urandom_range(63);
            if (pick < 35) begin
                send_encode(v);
            end else if (pick < 80) begin
                coded = varint_pack(v, n);
                cut = ($urandom_range(5) == 0 && n > 1) ? $urandom_range(n - 2) : n - 1;
                for (int k = 0; k <= cut; k++)
                    send_decode(coded[8*k +: 8],
                                (k == cut) ? ((k < n - 1) ? 1'b1 : 1'($urandom_range(1)))
                                           : 1'b0);
            end else if (pick < 92) begin
                send_decode(8'($urandom_range(255)), 1'($urandom_range(1)));
            end else begin
                for (int k = 0; k < MAX_GROUPS - 1; k++)
                    send_decode(8'h80 | 8'($urandom_range(127)), 1'b0);
                send_decode(8'($urandom_range(255)), 1'($urandom_range(1)));
            end
        end
        steady = 1'b0;
        wait_drained();
    endtask

    // The receiver stops for a long time while full-width encodes keep coming,
    // so the block has to back up and hold its input.
    task automatic test_output_stall();
        @(posedge i_clk);
        hold_req = 1'b1;
        for (int k = 0; k < 12; k++)
            send_encode({1'b1, 63'(rnd64())} ^ {64{1'($urandom_range(1))}});
        while (hold_req || hold_left != 0) @(posedge i_clk);
        wait_drained();
    endtask

    // Receiver: random backpressure, or a counted hold-off on request.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= 12);
        end
    end

    // Every result transaction is compared with the oldest expectation.
    t_res want, got;
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            got.is_value       = m_tuser[0];
            got.truncated      = m_tuser[1];
            got.overflow_error = m_tuser[2];
            got.out_byte       = m_tdata[7:0];
            got.value_out      = m_tdata[71:8];
            got.last           = m_tlast;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR %0t: unexpected result", $time,
                             " isv=%0b byte=%02h val=%016h last=%0b tr=%0b ov=%0b",
                             got.is_value, got.out_byte, got.value_out,
                             got.last, got.truncated, got.overflow_error);
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (got.is_value !== want.is_value || got.out_byte !== want.out_byte
                        || got.value_out !== want.value_out || got.last !== want.last
                        || got.truncated !== want.truncated
                        || got.overflow_error !== want.overflow_error) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("ERROR %0t: expected", $time,
                                 " isv=%0b byte=%02h val=%016h last=%0b tr=%0b ov=%0b",
                                 want.is_value, want.out_byte, want.value_out,
                                 want.last, want.truncated, want.overflow_error);
                        $display("             actual",
                                 " isv=%0b byte=%02h val=%016h last=%0b tr=%0b ov=%0b",
                                 got.is_value, got.out_byte, got.value_out,
                                 got.last, got.truncated, got.overflow_error);
                    end
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results still outstanding", pending_results.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_encode_edges();
        test_decode_edges();
        test_random_mix();
        test_output_stall();
        repeat (LATENCY_TAIL) @(posedge i_clk);
        errors += pending_results.size();
        $display("Ran %0d encode transactions and %0d decode bytes, %0d results compared,",
                 n_encodes, n_dec_bytes, n_checked);
        $display("among them %0d truncated values, %0d overflows and a %0d-cycle output stall.",
                 n_trunc, n_overflow, HOLD_CYCLES);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
